// ===== design/scb_pkg.sv =====
// Shared counter with barrier: package of field widths, reply status codes
// and the command/status structs between controller and datapath.
// No dependencies.
package scb_pkg;

  localparam int NODE_W = 12;
  localparam int LS_W   = 8;
  localparam int INC_W  = 16;
  localparam int VAL_W  = 32;
  localparam int ST_W   = 2;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_ZERO = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic accept;  // process the request on the input ports
    logic pop;     // move the next parked node into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic slot_free;  // output register empty or emptied this cycle
    logic rel_multi;  // current request releases more than one node
    logic rd_last;    // the entry being popped is the oldest waiter
  } sts_t;

endpackage

// ===== design/scb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module scb_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/scb_ctrl.sv =====
// Controller: accepts requests and sequences the drain of the waiting list.
// Depends on scb_pkg.
module scb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  scb_pkg::sts_t sts,
  output scb_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_DRAIN = 2'b10
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        in_ready   = sts.slot_free;
        cmd.accept = in_valid && sts.slot_free;
        if (cmd.accept && sts.rel_multi) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.pop = sts.slot_free;
        if (cmd.pop && sts.rd_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/scb_dp.sv =====
// Datapath: counter, waiting count, waiting-list RAM, drain pointer and the
// output register. Depends on scb_pkg and scb_ram.
module scb_dp #(
  parameter int MAX_WAITERS = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  scb_pkg::cmd_t                    cmd,
  output scb_pkg::sts_t                    sts,
  input  logic [scb_pkg::NODE_W-1:0]       requester_node,
  input  logic signed [scb_pkg::LS_W-1:0]  loop_size,
  input  logic [scb_pkg::INC_W-1:0]        increment,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [scb_pkg::NODE_W-1:0]       dest_node,
  output logic [scb_pkg::VAL_W-1:0]        value,
  output logic [scb_pkg::ST_W-1:0]         status,
  output logic                             last
);

  localparam int CW = $clog2(MAX_WAITERS + 1);
  localparam int AW = $clog2(MAX_WAITERS);
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_WAITERS);

  logic [scb_pkg::VAL_W-1:0]  counter, counter_next;
  logic [CW-1:0]              count, count_next;
  logic [AW-1:0]              rd_idx, rd_idx_next;
  logic [CW-1:0]              count_inc;
  logic [scb_pkg::LS_W-1:0]   mag;
  logic                       is_zero, is_pos, is_neg, is_full, release_hit;
  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_raddr;
  logic [scb_pkg::NODE_W-1:0] ram_q;
  logic                       out_load;
  logic [scb_pkg::NODE_W-1:0] dest_next;
  logic [scb_pkg::VAL_W-1:0]  value_next;
  logic [scb_pkg::ST_W-1:0]   status_next;
  logic                       last_next;

  assign count_inc   = count + CW'(1);
  assign mag         = scb_pkg::LS_W'(-loop_size);
  assign is_zero     = (loop_size == '0);
  assign is_neg      = loop_size[scb_pkg::LS_W-1];
  assign is_pos      = !is_zero && !is_neg;
  assign is_full     = (count == FULL_CNT);
  assign release_hit = is_neg && !is_full && (mag == scb_pkg::LS_W'(count_inc));

  assign sts.slot_free = !out_valid || out_ready;
  assign sts.rel_multi = release_hit && (count != '0);
  assign sts.rd_last   = (rd_idx == '0);

  assign ram_we    = cmd.accept && is_neg && !is_full;
  assign ram_re    = (cmd.accept && sts.rel_multi) || (cmd.pop && !sts.rd_last);
  assign ram_raddr = cmd.accept ? AW'(count - CW'(1)) : rd_idx - AW'(1);

  scb_ram #(
    .WIDTH (scb_pkg::NODE_W),
    .DEPTH (MAX_WAITERS)
  ) u_list (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(count)),
    .wdata (requester_node),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  always_comb begin
    counter_next = counter;
    count_next   = count;
    rd_idx_next  = rd_idx;
    out_load     = 1'b0;
    dest_next    = requester_node;
    value_next   = '0;
    status_next  = scb_pkg::ST_OK;
    last_next    = 1'b1;
    if (cmd.accept) begin
      priority if (is_zero) begin
        out_load    = 1'b1;
        status_next = scb_pkg::ST_ZERO;
      end else if (is_pos) begin
        out_load     = 1'b1;
        value_next   = counter;
        counter_next = counter + scb_pkg::VAL_W'(increment);
      end else if (is_full) begin
        out_load    = 1'b1;
        status_next = scb_pkg::ST_FULL;
      end else begin
        count_next = count_inc;
        if (release_hit) begin
          // newest waiter is the requester itself, straight from the input
          out_load   = 1'b1;
          value_next = counter;
          last_next  = (count == '0);
          if (count == '0) begin
            counter_next = '0;
            count_next   = '0;
          end else begin
            rd_idx_next = AW'(count - CW'(1));
          end
        end
      end
    end else if (cmd.pop) begin
      out_load   = 1'b1;
      dest_next  = ram_q;
      value_next = counter;
      last_next  = sts.rd_last;
      if (sts.rd_last) begin
        counter_next = '0;
        count_next   = '0;
      end else begin
        rd_idx_next = rd_idx - AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter   <= '0;
      count     <= '0;
      rd_idx    <= '0;
      out_valid <= 1'b0;
    end else begin
      counter <= counter_next;
      count   <= count_next;
      rd_idx  <= rd_idx_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      dest_node <= dest_next;
      value     <= value_next;
      status    <= status_next;
      last      <= last_next;
    end
  end

endmodule

// ===== design/shared_counter_with_barrier.sv =====
// Shared fetch-and-add counter with a release barrier: top level.
// Depends on scb_pkg, scb_ctrl and scb_dp.
//
// Usage:
//   Requests come in on in_valid/in_ready with requester_node, loop_size and
//   increment; replies leave on out_valid/out_ready with dest_node, value,
//   status and last. A transaction completes when valid and ready are high.
//   A positive loop size returns the count and then adds the increment.
//   A negative loop size parks the requester; when the number parked equals
//   its magnitude, every parked node gets the count, newest first, and the
//   count and list are cleared. Zero loop size, or a negative one when the
//   list is full, gives one reply with an error status.
// Timing:
//   Every reply is registered in the output register: loaded when its request
//   transaction is taken or, in a release, as the previous reply is handed
//   over. In a release the first reply comes straight from the request, each
//   later one from a list RAM read issued when the previous reply was loaded.
//   No request is taken until the last reply is loaded. A new request is
//   taken while a reply is being handed over.
// Reset and stalls:
//   rst clears the counter, the waiting count and out_valid; the reply fields
//   are not reset and the list RAM needs no clearing. While a reply is held
//   with out_ready low the block takes neither a request nor the next drained node.
module shared_counter_with_barrier #(
  parameter int MAX_WAITERS = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [scb_pkg::NODE_W-1:0]       requester_node,
  input  logic signed [scb_pkg::LS_W-1:0]  loop_size,
  input  logic [scb_pkg::INC_W-1:0]        increment,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [scb_pkg::NODE_W-1:0]       dest_node,
  output logic [scb_pkg::VAL_W-1:0]        value,
  output logic [scb_pkg::ST_W-1:0]         status,
  output logic                             last
);

  scb_pkg::cmd_t cmd;
  scb_pkg::sts_t sts;

  scb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  scb_dp #(
    .MAX_WAITERS (MAX_WAITERS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .requester_node (requester_node),
    .loop_size      (loop_size),
    .increment      (increment),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .dest_node      (dest_node),
    .value          (value),
    .status         (status),
    .last           (last)
  );

endmodule

// ===== design/scb_chk.sv =====
// Port-level checker for the shared counter with barrier, with its bind.
// Depends on scb_pkg and the top level shared_counter_with_barrier.
module scb_chk (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic [scb_pkg::NODE_W-1:0]       requester_node,
  input logic signed [scb_pkg::LS_W-1:0]  loop_size,
  input logic [scb_pkg::INC_W-1:0]        increment,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [scb_pkg::NODE_W-1:0]       dest_node,
  input logic [scb_pkg::VAL_W-1:0]        value,
  input logic [scb_pkg::ST_W-1:0]         status,
  input logic                             last
);

  // stalled reply holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(dest_node) && $stable(value)
      && $stable(status) && $stable(last))
    else $error("reply changed while stalled");

  // error replies are single and carry no count
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != scb_pkg::ST_OK |-> last && value == '0)
    else $error("error reply not final or non-zero value");

  // a fetch or zero request gets its reply in the next cycle
  a_fetch_reply: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !loop_size[scb_pkg::LS_W-1] |=>
      out_valid && last && dest_node == $past(requester_node)
      && status == ($past(loop_size) == '0 ? scb_pkg::ST_ZERO : scb_pkg::ST_OK))
    else $error("missing or wrong reply to fetch transaction");

  // no request is taken in the middle of a release
  a_no_take_in_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("request taken during release");

endmodule

bind shared_counter_with_barrier scb_chk u_chk (.*);

// ===== tb/sv/counter_reply_checker.sv =====
`timescale 1ns / 100ps
// Reply checker for shared_counter_with_barrier: watches the request and reply
// channels, predicts the replies from its own counter and parked-node list,
// and compares them field by field. Depends on scb_pkg.
module counter_reply_checker #(
  parameter int MAX_WAITERS = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [scb_pkg::NODE_W-1:0]        requester_node,
  input  logic signed [scb_pkg::LS_W-1:0]   loop_size,
  input  logic [scb_pkg::INC_W-1:0]         increment,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [scb_pkg::NODE_W-1:0]        dest_node,
  input  logic [scb_pkg::VAL_W-1:0]         value,
  input  logic [scb_pkg::ST_W-1:0]          status,
  input  logic                              last,
  output int                                fail_count,
  output int                                pending,
  output int                                reply_count,
  output int                                release_count
);

  typedef struct packed {
    logic [scb_pkg::NODE_W-1:0] node;
    logic [scb_pkg::VAL_W-1:0]  val;
    logic [scb_pkg::ST_W-1:0]   st;
    logic                       lst;
  } reply_t;

  reply_t                     expected_replies[$];
  logic [scb_pkg::VAL_W-1:0]  count_q;
  int                         parked_q;
  logic [scb_pkg::NODE_W-1:0] parked_nodes [MAX_WAITERS];

  task automatic predict_replies(input logic [scb_pkg::NODE_W-1:0] node,
                                 input logic signed [scb_pkg::LS_W-1:0] ls,
                                 input logic [scb_pkg::INC_W-1:0] inc);
    int mag;
    if (ls == 0) begin
      expected_replies.push_back(reply_t'{node, '0, scb_pkg::ST_ZERO, 1'b1});
    end else if (ls > 0) begin
      expected_replies.push_back(reply_t'{node, count_q, scb_pkg::ST_OK, 1'b1});
      count_q = count_q + scb_pkg::VAL_W'(inc);
    end else if (parked_q >= MAX_WAITERS) begin
      expected_replies.push_back(reply_t'{node, '0, scb_pkg::ST_FULL, 1'b1});
    end else begin
      parked_nodes[parked_q] = node;
      parked_q++;
      mag = -int'(ls);
      // release only on an exact match; newest waiter is answered first
      if (parked_q == mag) begin
        for (int k = parked_q - 1; k >= 0; k--)
          expected_replies.push_back(
            reply_t'{parked_nodes[k], count_q, scb_pkg::ST_OK, k == 0});
        count_q  = '0;
        parked_q = 0;
        release_count++;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [scb_pkg::VAL_W-1:0] exp_v,
                             input logic [scb_pkg::VAL_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0h got %0h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    reply_t exp_r;
    if (rst) begin
      count_q       = '0;
      parked_q      = 0;
      fail_count    = 0;
      reply_count   = 0;
      release_count = 0;
      expected_replies.delete();
    end else begin
      if (out_valid && out_ready) begin
        reply_count++;
        if (expected_replies.size() == 0) begin
          $display("%0t: reply with none expected: dest_node %0h value %0h status %0d last %0b",
                   $time, dest_node, value, status, last);
          fail_count++;
        end else begin
          exp_r = expected_replies.pop_front();
          check_field("dest_node", scb_pkg::VAL_W'(exp_r.node), scb_pkg::VAL_W'(dest_node));
          check_field("value", exp_r.val, value);
          check_field("status", scb_pkg::VAL_W'(exp_r.st), scb_pkg::VAL_W'(status));
          check_field("last", scb_pkg::VAL_W'(exp_r.lst), scb_pkg::VAL_W'(last));
        end
      end
      if (in_valid && in_ready)
        predict_replies(requester_node, loop_size, increment);
    end
    pending = expected_replies.size();
  end

endmodule

// ===== tb/sv/shared_counter_with_barrier_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for shared_counter_with_barrier: clock, reset, request and
// reply-side stimulus and the verdict. Depends on scb_pkg, the block and
// counter_reply_checker.
module shared_counter_with_barrier_tb;

  localparam int MAX_WAITERS  = 64;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 200;
  localparam int RANDOM_ITEMS = 24;
  localparam int TAIL_CYCLES  = 16;

  logic                            clk;
  logic                            rst;
  logic                            in_valid;
  logic                            in_ready;
  logic [scb_pkg::NODE_W-1:0]      requester_node;
  logic signed [scb_pkg::LS_W-1:0] loop_size;
  logic [scb_pkg::INC_W-1:0]       increment;
  logic                            out_valid;
  logic                            out_ready;
  logic [scb_pkg::NODE_W-1:0]      dest_node;
  logic [scb_pkg::VAL_W-1:0]       value;
  logic [scb_pkg::ST_W-1:0]        status;
  logic                            last;

  int fail_count, pending, reply_count, release_count;
  int cycles = 0;
  int sent = 0;
  int parked = 0;   // shadow of the list fill, only to shape the stimulus
  bit hold_off = 0;
  bit calm = 0;

  shared_counter_with_barrier #(.MAX_WAITERS(MAX_WAITERS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .requester_node(requester_node), .loop_size(loop_size), .increment(increment),
    .out_valid(out_valid), .out_ready(out_ready),
    .dest_node(dest_node), .value(value), .status(status), .last(last)
  );

  counter_reply_checker #(.MAX_WAITERS(MAX_WAITERS)) reply_chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .requester_node(requester_node), .loop_size(loop_size), .increment(increment),
    .out_valid(out_valid), .out_ready(out_ready),
    .dest_node(dest_node), .value(value), .status(status), .last(last),
    .fail_count(fail_count), .pending(pending),
    .reply_count(reply_count), .release_count(release_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("shared_counter_with_barrier_tb failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_req(input int node_i, input int ls_i, input int inc_i);
    int gap;
    requester_node <= scb_pkg::NODE_W'(node_i);
    loop_size      <= scb_pkg::LS_W'(ls_i);
    increment      <= scb_pkg::INC_W'(inc_i);
    in_valid       <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    if (ls_i < 0 && parked < MAX_WAITERS) begin
      parked++;
      if (parked == -ls_i) parked = 0;
    end
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // release whatever is parked with one matching request
  task automatic flush_list();
    if (parked > 0)
      send_req($urandom_range(0, 4095), -(parked + 1), $urandom_range(0, 65535));
  endtask

  task automatic send_fetch();
    send_req($urandom_range(0, 4095), $urandom_range(1, 127), $urandom_range(0, 65535));
  endtask

  // reply side: random stalls, calm stretches and one long hold-off on request
  initial begin
    int r, span;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 0;
      end else if (calm) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          out_ready <= 1'b1;
          span = $urandom_range(1, 12);
        end else if (r < 93) begin
          out_ready <= 1'b0;
          span = $urandom_range(1, 3);
        end else begin
          out_ready <= 1'b0;
          span = $urandom_range(10, 50);
        end
        repeat (span) @(posedge clk);
      end
    end
  end

  initial begin
    int r, size, target, start;
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    requester_node <= '0;
    loop_size      <= '0;
    increment      <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, zero loop size, barriers, overshoot
    send_req(0, 1, 0);
    send_req(4095, 127, 65535);
    send_req(2730, 64, 32768);
    send_req(1365, 1, 1);
    send_req(4095, 0, 65535);
    send_req(0, 0, 0);
    send_req(2049, -1, 7);
    send_req(1, 1, 0);
    send_req(100, 2, 500);
    send_req(1, -3, 0);
    send_req(2, -3, 0);
    send_req(3, -3, 0);
    send_req(9, 5, 1000);
    send_req(10, -2, 0);
    send_req(11, -1, 0);     // count has passed the magnitude: stays parked
    send_req(12, 0, 0);
    send_req(13, -128, 0);
    send_req(14, 3, 65535);
    send_req(15, -4, 0);
    send_req(4095, -2, 65535);
    send_req(0, -2, 0);
    wait_drained();

    // receiver holds off while requests keep coming
    hold_off = 1;
    calm = 1;
    repeat (12) send_fetch();
    calm = 0;
    wait_drained();

    start = sent;
    while (sent - start < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        size = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        if (parked + size > 60) flush_list();
        target = parked + size;
        repeat (size) begin
          if ($urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 4) == 0)
              send_req($urandom_range(0, 4095), 0, $urandom_range(0, 65535));
            else
              send_fetch();
          end
          // now and then a member with the wrong magnitude
          if ($urandom_range(0, 9) == 0)
            send_req($urandom_range(0, 4095), -$urandom_range(1, 128), $urandom_range(0, 65535));
          else
            send_req($urandom_range(0, 4095), -target, $urandom_range(0, 65535));
        end
      end else if (r < 80) begin
        send_fetch();
      end else if (r < 88) begin
        send_req($urandom_range(0, 4095), 0, $urandom_range(0, 65535));
      end else if (parked >= 50) begin
        flush_list();
      end else begin
        send_req($urandom_range(0, 4095), -$urandom_range(1, 128), $urandom_range(0, 65535));
      end
      if ($urandom_range(0, 29) == 0) begin
        wait_drained();
        calm = ($urandom_range(0, 1) == 1);
      end
    end
    calm = 0;
    wait_drained();

    // fill the list: once full it can never drain, so this comes last
    flush_list();
    while (parked < MAX_WAITERS)
      send_req($urandom_range(0, 4095), -$urandom_range(65, 128), $urandom_range(0, 65535));
    send_req(4095, -MAX_WAITERS, 65535);
    send_req(0, -1, 0);
    send_req(2730, -128, 1);
    send_fetch();
    send_req(1365, 0, 32768);
    send_fetch();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run covered %0d requests: fetches, zero loop sizes, barriers of mixed sizes,",
             sent);
    $display("a long receiver stall and a full list; %0d replies checked over %0d releases",
             reply_count, release_count);
    if (fail_count == 0 && pending == 0)
      $display("shared_counter_with_barrier_tb passed");
    else
      $display("shared_counter_with_barrier_tb failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/scb_pkg.sv
design/scb_ram.sv
design/scb_ctrl.sv
design/scb_dp.sv
design/shared_counter_with_barrier.sv
design/scb_chk.sv
tb/sv/counter_reply_checker.sv
tb/sv/shared_counter_with_barrier_tb.sv
